// File: sv/pcot_pkg.sv
// Shared types and constants for the pixel chain outline tracer.
package pcot_pkg;

	// Default widths
	localparam int COORD_BITS_DEF = 16;
	localparam int GEO_BITS_DEF   = 40;

	// Configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_LAT  = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_LONG = 2'd1;
	localparam logic [1:0] CFG_STEP_SIZE   = 2'd2;

	// Step size after reset: 1.0 with 32 fraction bits
	localparam int STEP_RESET_SHIFT = 32;

	// Pixel corners in counter-clockwise order
	typedef enum logic [1:0] {
		CORNER_NW = 2'd0,
		CORNER_SW = 2'd1,
		CORNER_SE = 2'd2,
		CORNER_NE = 2'd3
	} corner_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_EVAL   = 2'd1,
		ST_STROKE = 2'd2
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;      // latch the incoming pixel
		logic emit_single;  // chain start or error: one result
		logic apply_move;   // commit a valid move and load stroke counts
		logic stroke;       // one edge step, one result
	} pcot_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic started;      // a chain is open
		logic bad;          // latched pixel is not an 8-neighbor
		logic has_moves;    // the valid move produces at least one stroke
		logic out_free;     // output register can take a result this cycle
		logic last_stroke;  // the pending stroke is the final one
	} pcot_sts_t;

endpackage

// File: sv/pcot_ctrl.sv
// Controller state machine for the outline tracer.
module pcot_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pcot_pkg::pcot_sts_t sts,
	output pcot_pkg::pcot_cmd_t cmd
);
	import pcot_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_next;
	logic       single_case;

	assign single_case = !sts.started || sts.bad;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (single_case) begin
					if (sts.out_free) state_next = ST_IDLE;
				end else if (sts.has_moves) begin
					state_next = ST_STROKE;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_STROKE: begin
				if (sts.out_free && sts.last_stroke) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_EVAL: begin
				cmd.emit_single = single_case && sts.out_free;
				cmd.apply_move  = !single_case;
			end
			ST_STROKE: begin
				cmd.stroke = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: sv/pcot_datapath.sv
// Datapath of the outline tracer: chain state, step adder, output register.
module pcot_datapath #(
	parameter int COORD_BITS = pcot_pkg::COORD_BITS_DEF,
	parameter int GEO_BITS   = pcot_pkg::GEO_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [GEO_BITS-1:0]        cfg_data,
	// Pixel in
	input  logic [COORD_BITS-1:0]      in_x,
	input  logic [COORD_BITS-1:0]      in_y,
	input  logic                       in_last,
	// Result out
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [GEO_BITS-1:0] out_lat,
	output logic signed [GEO_BITS-1:0] out_long,
	output logic                       out_last,
	output logic                       out_err,
	// Control
	input  pcot_pkg::pcot_cmd_t        cmd,
	output pcot_pkg::pcot_sts_t        sts
);
	import pcot_pkg::*;

	localparam int STEP_BITS = GEO_BITS - 1;

	// Configuration registers
	logic [GEO_BITS-1:0]  origin_lat_q, origin_long_q;
	logic [STEP_BITS-1:0] step_q;

	// Latched pixel
	logic [COORD_BITS-1:0] in_x_q, in_y_q;
	logic                  in_last_q;

	// Chain state
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic                  prev_valid_q, started_q;
	corner_t               corner_q, cp_q;
	logic [GEO_BITS-1:0]   cur_lat_q, cur_long_q;
	logic [2:0]            cnt1_q, total_q;

	// Output register
	logic                  out_valid_q, out_last_q, out_err_q;
	logic [GEO_BITS-1:0]   out_lat_q, out_long_q;

	// Neighbor classification
	logic [COORD_BITS:0] ix_w, iy_w, cx_w, cy_w;
	logic dx_zero, dx_pos, dx_neg, dy_zero, dy_pos, dy_neg;
	logic bad, diag, backtrack;
	corner_t target, cp_new;
	logic [1:0] t_minus_c, close_n;
	logic [2:0] n1, n2, total_new;

	// Stroke arithmetic
	logic [GEO_BITS-1:0] step_ext, lat_next, long_next;
	corner_t corner_inc, corner_after;

	logic out_free;

	assign ix_w = {1'b0, in_x_q};
	assign iy_w = {1'b0, in_y_q};
	assign cx_w = {1'b0, cur_x_q};
	assign cy_w = {1'b0, cur_y_q};

	// Offsets of the new pixel relative to the current one
	always_comb begin
		dx_zero = (ix_w == cx_w);
		dx_pos  = (ix_w == cx_w + (COORD_BITS+1)'(1));
		dx_neg  = (cx_w == ix_w + (COORD_BITS+1)'(1));
		dy_zero = (iy_w == cy_w);
		dy_pos  = (iy_w == cy_w + (COORD_BITS+1)'(1));
		dy_neg  = (cy_w == iy_w + (COORD_BITS+1)'(1));
		bad     = !(dx_zero || dx_pos || dx_neg) || !(dy_zero || dy_pos || dy_neg)
			|| (dx_zero && dy_zero);
		diag    = !dx_zero && !dy_zero;
		backtrack = prev_valid_q && (prev_x_q == in_x_q) && (prev_y_q == in_y_q);
	end

	// Corner touching the new pixel, stroke counts and re-expressed corner
	always_comb begin
		if (dx_neg && !dy_pos) begin
			target = CORNER_NW;
		end else if (dy_pos && !dx_pos) begin
			target = CORNER_SW;
		end else if (dx_pos && !dy_neg) begin
			target = CORNER_SE;
		end else begin
			target = CORNER_NE;
		end
		t_minus_c = 2'(target - corner_q);
		if (target == corner_q) begin
			n1 = backtrack ? 3'd4 : 3'd0;
		end else begin
			n1 = {1'b0, t_minus_c};
		end
		cp_new    = corner_t'(2'(target + (diag ? 2'd2 : 2'd3)));
		close_n   = 2'(2'd0 - cp_new);
		n2        = in_last_q ? {1'b0, close_n} : 3'd0;
		total_new = 3'(n1 + n2);
	end

	// One counter-clockwise edge step
	always_comb begin
		step_ext  = {1'b0, step_q};
		lat_next  = cur_lat_q;
		long_next = cur_long_q;
		case (corner_q)
			CORNER_NW: lat_next  = cur_lat_q + step_ext;
			CORNER_SW: long_next = cur_long_q + step_ext;
			CORNER_SE: lat_next  = cur_lat_q - step_ext;
			CORNER_NE: long_next = cur_long_q - step_ext;
			default:   lat_next  = cur_lat_q;
		endcase
		corner_inc   = corner_t'(2'(corner_q + 2'd1));
		corner_after = (cnt1_q == 3'd1) ? cp_q : corner_inc;
	end

	assign out_free = !out_valid_q || out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_lat_q  <= '0;
			origin_long_q <= '0;
			step_q        <= STEP_BITS'(1) << STEP_RESET_SHIFT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_LAT:  origin_lat_q  <= cfg_data;
				CFG_ORIGIN_LONG: origin_long_q <= cfg_data;
				CFG_STEP_SIZE:   step_q        <= cfg_data[STEP_BITS-1:0];
				default:         ;
			endcase
		end
	end

	// Pixel latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_x_q    <= in_x;
			in_y_q    <= in_y;
			in_last_q <= in_last;
		end
	end

	// Chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_valid_q <= 1'b0;
			started_q    <= 1'b0;
			corner_q     <= CORNER_NW;
			cp_q         <= CORNER_NW;
			cur_lat_q    <= '0;
			cur_long_q   <= '0;
			cnt1_q       <= '0;
			total_q      <= '0;
		end else if (cmd.emit_single) begin
			// chain start loads the origin; an error leaves all state alone
			if (!started_q) begin
				cur_x_q      <= in_x_q;
				cur_y_q      <= in_y_q;
				prev_valid_q <= 1'b0;
				corner_q     <= CORNER_NW;
				cur_lat_q    <= origin_lat_q;
				cur_long_q   <= origin_long_q;
				started_q    <= !in_last_q;
			end
		end else if (cmd.apply_move) begin
			prev_x_q     <= cur_x_q;
			prev_y_q     <= cur_y_q;
			cur_x_q      <= in_x_q;
			cur_y_q      <= in_y_q;
			prev_valid_q <= !in_last_q;
			started_q    <= !in_last_q;
			cp_q         <= cp_new;
			cnt1_q       <= n1;
			total_q      <= total_new;
			if (n1 == 3'd0) corner_q <= cp_new;
		end else if (cmd.stroke) begin
			cur_lat_q  <= lat_next;
			cur_long_q <= long_next;
			corner_q   <= corner_after;
			total_q    <= total_q - 3'd1;
			if (cnt1_q != 3'd0) cnt1_q <= cnt1_q - 3'd1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_single || cmd.stroke) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			out_lat_q  <= started_q ? cur_lat_q : origin_lat_q;
			out_long_q <= started_q ? cur_long_q : origin_long_q;
			out_last_q <= 1'b1;
			out_err_q  <= started_q;
		end else if (cmd.stroke) begin
			out_lat_q  <= lat_next;
			out_long_q <= long_next;
			out_last_q <= (total_q == 3'd1);
			out_err_q  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_lat   = out_lat_q;
	assign out_long  = out_long_q;
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

	assign sts.started     = started_q;
	assign sts.bad         = bad;
	assign sts.has_moves   = (total_new != 3'd0);
	assign sts.out_free    = out_free;
	assign sts.last_stroke = (total_q == 3'd1);

endmodule

// File: sv/pixel_chain_outline_tracer.sv
// Top level of the pixel chain outline tracer.
// Takes an 8-connected chain of boundary pixels and emits the vertices of its
// outline walked counter-clockwise along pixel edges, with the first pixel of a
// chain placed at the origin registers and step_size per pixel edge. Each pixel
// is taken as a request, then its neighbor is classified, then it emits one vertex
// per edge step (0 to 7 of them) from the step adder, one vertex per cycle into
// the output register unless downstream stalls; a chain start or a non-adjacent
// pixel writes its one vertex during classification.
// The output register lets the next pixel be taken while the last vertex waits.
// The user must write configuration only between pixels; the block does not enforce it.
module pixel_chain_outline_tracer #(
	parameter int COORD_BITS = pcot_pkg::COORD_BITS_DEF,
	parameter int GEO_BITS   = pcot_pkg::GEO_BITS_DEF,
	localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * GEO_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [GEO_BITS-1:0] cfg_data,
	// Pixel stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,   // pixel_x, pixel_y, zero pad
	input  logic                s_axis_tlast,   // chain_end
	// Vertex stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata,   // vertex_lat, vertex_long, zero pad
	output logic                m_axis_tlast,   // run_last
	output logic                m_axis_tuser    // not_adjacent
);
	import pcot_pkg::*;

	pcot_cmd_t cmd;
	pcot_sts_t sts;
	logic signed [GEO_BITS-1:0] vertex_lat, vertex_long;

	assign cfg_ready = 1'b1;

	pcot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcot_datapath #(
		.COORD_BITS (COORD_BITS),
		.GEO_BITS   (GEO_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_x      (s_axis_tdata[COORD_BITS-1:0]),
		.in_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_lat   (vertex_lat),
		.out_long  (vertex_long),
		.out_last  (m_axis_tlast),
		.out_err   (m_axis_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Pack the vertex, lowest field first
	always_comb begin
		m_axis_tdata                          = '0;
		m_axis_tdata[GEO_BITS-1:0]            = vertex_lat;
		m_axis_tdata[2*GEO_BITS-1:GEO_BITS]   = vertex_long;
	end

endmodule

// File: sv/pcot_checker.sv
// Port-level assertions for the outline tracer, bound to the top level.
module pcot_checker #(
	parameter int COORD_BITS = pcot_pkg::COORD_BITS_DEF,
	parameter int GEO_BITS   = pcot_pkg::GEO_BITS_DEF,
	localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * GEO_BITS + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [1:0]          cfg_index,
	input logic [GEO_BITS-1:0] cfg_data,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic [IN_W-1:0]     s_axis_tdata,
	input logic                s_axis_tlast,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OUT_W-1:0]    m_axis_tdata,
	input logic                m_axis_tlast,
	input logic                m_axis_tuser
);

	// An error result is always the only result of its pixel
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("not_adjacent result without run_last");

	// One pixel at a time: a taken request closes the input for the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("pixel taken while the previous one is being classified");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind pixel_chain_outline_tracer pcot_checker #(
	.COORD_BITS (COORD_BITS),
	.GEO_BITS   (GEO_BITS)
) u_pcot_checker (.*);
